>>> sv/stapwm_pkg.sv
// shared types and constants for the six-thruster allocation block
package stapwm_pkg;

  localparam int NUM_MOTORS = 6;
  localparam int MIDX_W     = 3;
  localparam int IN_W       = 16;
  localparam int PWM_W      = 13;
  localparam int ALPHA_W    = 16;
  localparam int INV_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RAW_W      = 17;

  localparam logic [MIDX_W-1:0] LAST_MOTOR = MIDX_W'(NUM_MOTORS - 1);

  localparam int DEADBAND_SPAN = 1200;
  localparam logic [PWM_W-1:0] PWM_FAILSAFE = 13'd5940;
  localparam logic [PWM_W-1:0] PWM_MAX      = 13'd7300;
  localparam logic [PWM_W-1:0] PWM_POS_BASE = 13'd6100;
  localparam logic [PWM_W-1:0] PWM_ZERO     = 13'd5900;
  localparam logic [PWM_W-1:0] PWM_NEG_BASE = 13'd5700;
  localparam logic [PWM_W-1:0] PWM_MIN      = 13'd4500;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd5243;
  localparam logic [INV_W-1:0]   INV_RESET   = 32'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_THRUST_SCALE = 2'd1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUBLISH
  } ctl_state_t;

  typedef struct packed {
    logic              load_we;
    logic              start;
    logic              issue;
    logic [MIDX_W-1:0] motor;
    logic              publish;
    logic              failsafe;
  } dp_cmd_t;

  typedef struct packed {
    logic wb_done;
  } dp_stat_t;

endpackage

>>> sv/stapwm_if.sv
// valid/ready channel interfaces for input words, result words and config writes
interface stapwm_in_if;
  import stapwm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [MIDX_W-1:0]      coef_row;
  logic [MIDX_W-1:0]      coef_col;
  logic signed [IN_W-1:0] coef_value;
  logic signed [IN_W-1:0] wrench_0;
  logic signed [IN_W-1:0] wrench_1;
  logic signed [IN_W-1:0] wrench_2;
  logic signed [IN_W-1:0] wrench_3;
  logic signed [IN_W-1:0] wrench_4;
  logic signed [IN_W-1:0] wrench_5;
  logic                   failsafe;
  modport source (output valid, opcode, coef_row, coef_col, coef_value, wrench_0, wrench_1,
                  wrench_2, wrench_3, wrench_4, wrench_5, failsafe, input ready);
  modport sink   (input valid, opcode, coef_row, coef_col, coef_value, wrench_0, wrench_1,
                  wrench_2, wrench_3, wrench_4, wrench_5, failsafe, output ready);
endinterface

interface stapwm_out_if;
  import stapwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] pwm_motor_0;
  logic [PWM_W-1:0] pwm_motor_1;
  logic [PWM_W-1:0] pwm_motor_2;
  logic [PWM_W-1:0] pwm_motor_3;
  logic [PWM_W-1:0] pwm_motor_4;
  logic [PWM_W-1:0] pwm_motor_5;
  modport source (output valid, pwm_motor_0, pwm_motor_1, pwm_motor_2, pwm_motor_3,
                  pwm_motor_4, pwm_motor_5, input ready);
  modport sink   (input valid, pwm_motor_0, pwm_motor_1, pwm_motor_2, pwm_motor_3,
                  pwm_motor_4, pwm_motor_5, output ready);
endinterface

interface stapwm_cfg_if;
  import stapwm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/six_thruster_allocation_pwm.sv
// top level of the six-thruster allocation and pwm mapping block
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+---------------------------------------------
//   in_ch    | in  | valid/ready        | opcode, coef row/col/value, wrench 0..5, failsafe
//   out_ch   | out | valid/ready        | pwm_motor_0..5 compare values
//   cfg_ch   | in  | valid/ready        | register index, write data
//
// a load word is taken without leaving the idle state; a failsafe update goes straight to publish
// a normal update shows its result and frees in_ch in the same cycle, after:
//   six row issues through the coefficient memory read port and six product lanes, then
//   a ten-stage scale/filter/map pipeline, a drain check and the publish cycle
// synchronous active-low reset clears filters, config to defaults and all control state
// the result sits in an output register, so in_ch accepts the next word while it waits
// a stalled out_ch holds the result; only a new update's publish waits for it to drain
module six_thruster_allocation_pwm #(
  parameter int COEF_WIDTH   = 16,
  parameter int FILTER_WIDTH = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  stapwm_in_if.sink     in_ch,
  stapwm_out_if.source  out_ch,
  stapwm_cfg_if.sink    cfg_ch
);
  import stapwm_pkg::*;

  // configuration registers
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [INV_W-1:0]   inv_r, inv_nxt;

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic signed [IN_W-1:0] wrench [NUM_MOTORS];
  logic [PWM_W-1:0]       pwm [NUM_MOTORS];

  // config port is always ready; writes take effect at once, so the user must keep them between updates (not enforced)
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    alpha_nxt = alpha_r;
    inv_nxt   = inv_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FILTER_ALPHA:     alpha_nxt = cfg_ch.data[ALPHA_W-1:0];
        CFG_INV_THRUST_SCALE: inv_nxt   = cfg_ch.data[INV_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      inv_r   <= INV_RESET;
    end else begin
      alpha_r <= alpha_nxt;
      inv_r   <= inv_nxt;
    end
  end

  // gather wrench components into lanes
  assign wrench[0] = in_ch.wrench_0;
  assign wrench[1] = in_ch.wrench_1;
  assign wrench[2] = in_ch.wrench_2;
  assign wrench[3] = in_ch.wrench_3;
  assign wrench[4] = in_ch.wrench_4;
  assign wrench[5] = in_ch.wrench_5;

  // sequencer
  stapwm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_opcode   (in_ch.opcode),
    .in_failsafe (in_ch.failsafe),
    .in_row      (in_ch.coef_row),
    .in_col      (in_ch.coef_col),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // arithmetic and state
  stapwm_dp #(
    .COEF_WIDTH   (COEF_WIDTH),
    .FILTER_WIDTH (FILTER_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .coef_row     (in_ch.coef_row),
    .coef_col     (in_ch.coef_col),
    .coef_value   (in_ch.coef_value),
    .wrench       (wrench),
    .filter_alpha (alpha_r),
    .inv_scale    (inv_r),
    .pwm          (pwm)
  );

  // result word
  assign out_ch.pwm_motor_0 = pwm[0];
  assign out_ch.pwm_motor_1 = pwm[1];
  assign out_ch.pwm_motor_2 = pwm[2];
  assign out_ch.pwm_motor_3 = pwm[3];
  assign out_ch.pwm_motor_4 = pwm[4];
  assign out_ch.pwm_motor_5 = pwm[5];

endmodule

>>> sv/stapwm_ctrl.sv
// controller state machine: sequences loads, motor issue, drain and result publish
module stapwm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic                          in_failsafe,
  input  logic [stapwm_pkg::MIDX_W-1:0] in_row,
  input  logic [stapwm_pkg::MIDX_W-1:0] in_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stapwm_pkg::dp_cmd_t           cmd,
  input  stapwm_pkg::dp_stat_t          stat
);
  import stapwm_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [MIDX_W-1:0] cnt_r, cnt_nxt;
  logic              fs_r, fs_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fs_r        <= fs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fs_nxt        = fs_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.motor     = cnt_r;
    cmd.failsafe  = fs_r;
    accept        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          if (op_t'(in_opcode) == OP_LOAD) begin
            cmd.load_we = (in_row < MIDX_W'(NUM_MOTORS)) && (in_col < MIDX_W'(NUM_MOTORS));
          end else if (in_failsafe) begin
            fs_nxt    = 1'b1;
            state_nxt = ST_PUBLISH;
          end else begin
            fs_nxt    = 1'b0;
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (cnt_r == LAST_MOTOR) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.wb_done) begin
          state_nxt = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/stapwm_dp.sv
// datapath: coefficient memory, row products, scaling, per-motor filter and deadband map
module stapwm_dp #(
  parameter int COEF_WIDTH   = 16,
  parameter int FILTER_WIDTH = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stapwm_pkg::dp_cmd_t                  cmd,
  output stapwm_pkg::dp_stat_t                 stat,
  input  logic [stapwm_pkg::MIDX_W-1:0]        coef_row,
  input  logic [stapwm_pkg::MIDX_W-1:0]        coef_col,
  input  logic signed [stapwm_pkg::IN_W-1:0]   coef_value,
  input  logic signed [stapwm_pkg::IN_W-1:0]   wrench [stapwm_pkg::NUM_MOTORS],
  input  logic [stapwm_pkg::ALPHA_W-1:0]       filter_alpha,
  input  logic [stapwm_pkg::INV_W-1:0]         inv_scale,
  output logic [stapwm_pkg::PWM_W-1:0]         pwm [stapwm_pkg::NUM_MOTORS]
);
  import stapwm_pkg::*;

  localparam int CW     = COEF_WIDTH;
  localparam int FW     = FILTER_WIDTH;
  localparam int ROW_W  = NUM_MOTORS * CW;
  localparam int PROD_W = CW + IN_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int MAG_W  = (SUM_W > 32) ? SUM_W : 33;
  localparam int HI_W   = MAG_W - 32;
  localparam int HP_W   = HI_W + INV_W;
  localparam int QS_W   = HP_W + 1;
  localparam int DW     = ((FW > RAW_W) ? FW : RAW_W) + 1;
  localparam int NW     = DW + 1;
  localparam int NSTG   = 10;

  localparam logic signed [FW-1:0] SPAN_P = FW'(DEADBAND_SPAN);
  localparam logic signed [FW-1:0] SPAN_N = -SPAN_P;

  // coefficient memory, one row per motor
  logic [ROW_W-1:0] coef_mem [NUM_MOTORS];
  logic [ROW_W-1:0] row_r;

  logic signed [IN_W-1:0]   wrench_r [NUM_MOTORS];
  logic                     v_r [1:NSTG];
  logic [MIDX_W-1:0]        m_r [1:NSTG];

  logic signed [CW-1:0]     coef_sel [NUM_MOTORS];
  logic signed [PROD_W-1:0] prod_r [NUM_MOTORS];
  logic signed [SUM_W-1:0]  sum_r;
  logic                     neg4_r, neg5_r;
  logic [MAG_W-1:0]         mag_r;
  logic [63:0]              lo_r;
  logic [HP_W-1:0]          hi_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [DW-1:0]     diff_r;
  logic signed [FW-1:0]     old7_r, old8_r, old9_r;
  logic                     dneg_r, sneg_r;
  logic [DW-1:0]            dmag_r, smag_r;
  logic signed [FW-1:0]     new_r;
  logic signed [FW-1:0]     filt_r [NUM_MOTORS];
  logic [PWM_W-1:0]         pwm_buf_r [NUM_MOTORS];
  logic [PWM_W-1:0]         pwm_out_r [NUM_MOTORS];

  // combinational helpers
  logic signed [SUM_W-1:0]  sum_c;
  logic [SUM_W-1:0]         abs_c;
  logic [QS_W-1:0]          qsum_c;
  logic [15:0]              q16_c;
  logic signed [RAW_W-1:0]  raw_c;
  logic signed [FW-1:0]     cur_c;
  logic [DW+ALPHA_W-1:0]    sprod_c;
  logic signed [NW-1:0]     step_c;
  logic signed [NW-1:0]     nsum_c;
  logic signed [FW-1:0]     new_c;
  logic [PWM_W-1:0]         map_c;

  // memory write port and registered row read
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      coef_mem[coef_row][coef_col*CW +: CW] <= CW'(coef_value);
    end
    if (cmd.issue) begin
      row_r <= coef_mem[cmd.motor];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int c = 0; c < NUM_MOTORS; c++) begin
        wrench_r[c] <= wrench[c];
      end
    end
  end

  // stage valid and motor tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NSTG; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v_r[1] <= cmd.issue;
      for (int s = 2; s <= NSTG; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r[1] <= cmd.motor;
    for (int s = 2; s <= NSTG; s++) begin
      m_r[s] <= m_r[s-1];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_MOTORS; c++) begin
      coef_sel[c] = signed'(row_r[c*CW +: CW]);
    end
    sum_c = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
          + SUM_W'(prod_r[3]) + SUM_W'(prod_r[4]) + SUM_W'(prod_r[5]);
    abs_c  = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    qsum_c = QS_W'(hi_r) + QS_W'(lo_r[63:32]);
    // shift by four and saturate to the raw drive limit
    q16_c  = (|qsum_c[QS_W-1:20]) ? 16'hFFFF : qsum_c[19:4];
    raw_c  = neg5_r ? -signed'({1'b0, q16_c}) : signed'({1'b0, q16_c});
    cur_c  = filt_r[m_r[6]];
    sprod_c = dmag_r * filter_alpha;
    step_c = sneg_r ? -signed'(NW'(smag_r)) : signed'(NW'(smag_r));
    nsum_c = NW'(old9_r) + step_c;
    new_c  = nsum_c[FW-1:0];
  end

  // datapath pipeline registers
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_MOTORS; c++) begin
      prod_r[c] <= coef_sel[c] * wrench_r[c];
    end
    sum_r  <= sum_c;
    neg4_r <= sum_r[SUM_W-1];
    mag_r  <= MAG_W'(abs_c);
    neg5_r <= neg4_r;
    lo_r   <= mag_r[31:0] * inv_scale;
    hi_r   <= mag_r[MAG_W-1:32] * inv_scale;
    raw_r  <= raw_c;
    diff_r <= DW'(raw_r) - DW'(cur_c);
    old7_r <= cur_c;
    dneg_r <= diff_r[DW-1];
    dmag_r <= diff_r[DW-1] ? DW'(~diff_r + 1'b1) : DW'(diff_r);
    old8_r <= old7_r;
    smag_r <= sprod_c[DW+ALPHA_W-1:ALPHA_W];
    sneg_r <= dneg_r;
    old9_r <= old8_r;
    new_r  <= new_c;
  end

  // filter state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        filt_r[m] <= '0;
      end
    end else if (v_r[9]) begin
      filt_r[m_r[9]] <= new_c;
    end
  end

  // deadband around neutral
  always_comb begin
    if (new_r > SPAN_P) begin
      map_c = PWM_MAX;
    end else if (new_r > FW'(0)) begin
      map_c = PWM_POS_BASE + new_r[PWM_W-1:0];
    end else if (new_r == FW'(0)) begin
      map_c = PWM_ZERO;
    end else if (new_r >= SPAN_N) begin
      map_c = PWM_NEG_BASE + new_r[PWM_W-1:0];
    end else begin
      map_c = PWM_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[NSTG]) begin
      pwm_buf_r[m_r[NSTG]] <= map_c;
    end
    if (cmd.publish) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        pwm_out_r[m] <= cmd.failsafe ? PWM_FAILSAFE : pwm_buf_r[m];
      end
    end
  end

  assign stat.wb_done = v_r[NSTG] && (m_r[NSTG] == LAST_MOTOR);

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      pwm[m] = pwm_out_r[m];
    end
  end

endmodule

>>> sv/stapwm_chk.sv
// port-level checker for the six-thruster allocation block, with its bind
module stapwm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_opcode,
  input logic                         in_failsafe,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stapwm_pkg::PWM_W-1:0] pwm_0,
  input logic [stapwm_pkg::PWM_W-1:0] pwm_5
);
  import stapwm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pwm_0) && $stable(pwm_5))
    else $error("result changed while stalled");

  // a load word never makes a result appear
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("load word produced a result");

  // a normal update occupies the block
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_UPDATE) && !in_failsafe |=> !in_ready)
    else $error("input accepted during update");

  // a failsafe update accepted with no result waiting gives the failsafe value on motors 0 and 5
  a_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_UPDATE) && in_failsafe && !out_valid |->
      ##2 (out_valid && (pwm_0 == PWM_FAILSAFE) && (pwm_5 == PWM_FAILSAFE)))
    else $error("failsafe result missing or wrong");

endmodule

bind six_thruster_allocation_pwm stapwm_chk u_stapwm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_opcode   (in_ch.opcode),
  .in_failsafe (in_ch.failsafe),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pwm_0       (out_ch.pwm_motor_0),
  .pwm_5       (out_ch.pwm_motor_5)
);

>>> dv/alloc_pwm_checker.sv
// checker that predicts and compares the pwm compare values of the allocation block
module alloc_pwm_checker #(
  parameter int COEF_WIDTH   = 16,
  parameter int FILTER_WIDTH = 18
) (
  input  logic  clk,
  input  logic  rst_n,
  stapwm_in_if  in_ch,
  stapwm_out_if out_ch,
  stapwm_cfg_if cfg_ch,
  output int    mismatch_count,
  output int    pending_words
);
  import stapwm_pkg::*;

  localparam longint RAW_LIMIT = 65535;

  typedef logic [NUM_MOTORS-1:0][PWM_W-1:0] pwm_set_t;

  logic signed [COEF_WIDTH-1:0]   coef_tbl   [NUM_MOTORS*NUM_MOTORS];
  logic signed [FILTER_WIDTH-1:0] motor_filt [NUM_MOTORS];
  logic [ALPHA_W-1:0]             alpha_q;
  logic [INV_W-1:0]               inv_scale_q;
  pwm_set_t                       pwm_expected_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [PWM_W-1:0] deadband_pwm(input longint d);
    if (d > DEADBAND_SPAN)   return PWM_MAX;
    if (d > 0)               return PWM_W'(longint'(PWM_POS_BASE) + d);
    if (d == 0)              return PWM_ZERO;
    if (d >= -DEADBAND_SPAN) return PWM_W'(longint'(PWM_NEG_BASE) + d);
    return PWM_MIN;
  endfunction

  // table times wrench, scale, saturate, low-pass, deadband map; updates the filters
  function automatic pwm_set_t allocate_and_map(input logic signed [IN_W-1:0] wr [NUM_MOTORS]);
    pwm_set_t    res;
    longint      sum;
    longint      raw;
    longint      diff;
    longint      nudge;
    logic [63:0] mag;
    logic [95:0] scaled;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      sum = 0;
      for (int c = 0; c < NUM_MOTORS; c++)
        sum += longint'(coef_tbl[m*NUM_MOTORS + c]) * longint'(wr[c]);
      // q12.20 sum times q16.16 reciprocal, back to counts, toward zero
      mag    = (sum < 0) ? 64'(-sum) : 64'(sum);
      scaled = 96'(mag) * 96'(inv_scale_q);
      mag    = 64'(scaled >> 36);
      if (mag > 64'(RAW_LIMIT)) mag = 64'(RAW_LIMIT);
      raw    = (sum < 0) ? -longint'(mag) : longint'(mag);
      diff   = raw - longint'(motor_filt[m]);
      mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
      mag    = (mag * 64'(alpha_q)) >> 16;
      nudge  = (diff < 0) ? -longint'(mag) : longint'(mag);
      motor_filt[m] = FILTER_WIDTH'(longint'(motor_filt[m]) + nudge);
      res[m] = deadband_pwm(longint'(motor_filt[m]));
    end
    return res;
  endfunction

  task automatic take_word();
    logic signed [IN_W-1:0] wr [NUM_MOTORS];
    if (in_ch.opcode == OP_LOAD) begin
      // out-of-range row or column is dropped
      if (in_ch.coef_row <= LAST_MOTOR && in_ch.coef_col <= LAST_MOTOR)
        coef_tbl[in_ch.coef_row * NUM_MOTORS + in_ch.coef_col] = in_ch.coef_value;
    end else if (in_ch.failsafe) begin
      pwm_expected_q.push_back({NUM_MOTORS{PWM_FAILSAFE}});
    end else begin
      wr = '{in_ch.wrench_0, in_ch.wrench_1, in_ch.wrench_2,
             in_ch.wrench_3, in_ch.wrench_4, in_ch.wrench_5};
      pwm_expected_q.push_back(allocate_and_map(wr));
    end
  endtask

  task automatic check_result();
    pwm_set_t got;
    pwm_set_t want;
    got = {out_ch.pwm_motor_5, out_ch.pwm_motor_4, out_ch.pwm_motor_3,
           out_ch.pwm_motor_2, out_ch.pwm_motor_1, out_ch.pwm_motor_0};
    if (pwm_expected_q.size() == 0) begin
      report_mismatch("unexpected result word, pwm_motor_0", got[0], 0);
      return;
    end
    want = pwm_expected_q.pop_front();
    for (int m = 0; m < NUM_MOTORS; m++)
      if (got[m] !== want[m])
        report_mismatch($sformatf("pwm_motor_%0d", m), got[m], want[m]);
  endtask

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_q     = ALPHA_RESET;
      inv_scale_q = INV_RESET;
      foreach (coef_tbl[i]) coef_tbl[i] = '0;
      foreach (motor_filt[i]) motor_filt[i] = '0;
      pwm_expected_q.delete();
    end else begin
      // result first: a word accepted now cannot be the one leaving now
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_FILTER_ALPHA:     alpha_q = cfg_ch.data[ALPHA_W-1:0];
          CFG_INV_THRUST_SCALE: inv_scale_q = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) take_word();
    end
    pending_words = pwm_expected_q.size();
  end

endmodule

>>> dv/tb_top.sv
// testbench top: stimulus, receiver, watchdog and verdict for the allocation block
module tb_top;
  import stapwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on any channel
  localparam int SETTLE_CYCLES  = 24;    // margin past the end of an update
  localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off to back up the input
  localparam int PHASE_WORDS    = 230;
  localparam int GAP_CHUNK      = 40;    // words between re-rolls of the idling mix

  localparam logic signed [IN_W-1:0] COEF_ONE = 16'sd4096;  // 1.0 in q4.12
  localparam logic signed [IN_W-1:0] WR_MAX   = 16'sh7fff;
  localparam logic signed [IN_W-1:0] WR_MIN   = 16'sh8000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    op_t                    opcode;
    logic [MIDX_W-1:0]      row;
    logic [MIDX_W-1:0]      col;
    logic signed [IN_W-1:0] coef;
    logic signed [IN_W-1:0] wrench [NUM_MOTORS];
    logic                   failsafe;
  } cmd_word_t;

  logic clk;
  logic rst_n;
  bit   send_gaps;     // only the stimulus process touches this one
  bit   recv_gaps;
  int   squeeze_reqs;  // bumped by stimulus, consumed by the receiver
  int   mismatch_count;
  int   pending_words;

  stapwm_in_if  in_ch ();
  stapwm_out_if out_ch ();
  stapwm_cfg_if cfg_ch ();

  six_thruster_allocation_pwm i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  alloc_pwm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- word builders

  // every field random, including the ones the opcode makes don't-care
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        style;
    w.opcode   = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_UPDATE;
    // mostly legal table slots, now and then a row or column past the last motor
    w.row      = ($urandom_range(0, 7) == 0) ? MIDX_W'($urandom_range(0, 7))
                                              : MIDX_W'($urandom_range(0, 5));
    w.col      = ($urandom_range(0, 7) == 0) ? MIDX_W'($urandom_range(0, 7))
                                              : MIDX_W'($urandom_range(0, 5));
    w.coef     = ($urandom_range(0, 1) == 0) ? IN_W'($urandom)
                                              : IN_W'($urandom_range(0, 16384) - 8192);
    w.failsafe = ($urandom_range(0, 9) == 0);
    // one magnitude style per word so the sums land in every deadband region
    style = $urandom_range(0, 3);
    for (int c = 0; c < NUM_MOTORS; c++) begin
      case (style)
        0: w.wrench[c] = IN_W'($urandom);
        1: w.wrench[c] = IN_W'($urandom_range(0, 6000) - 3000);
        2: w.wrench[c] = IN_W'($urandom_range(0, 128) - 64);
        default: begin
          case ($urandom_range(0, 2))
            0:       w.wrench[c] = '0;
            1:       w.wrench[c] = WR_MAX;
            default: w.wrench[c] = WR_MIN;
          endcase
        end
      endcase
    end
    return w;
  endfunction

  function automatic cmd_word_t update_word(input int w0, input int w1, input int w2,
                                            input int w3, input int w4, input int w5,
                                            input bit fs);
    cmd_word_t w;
    w          = random_word();
    w.opcode   = OP_UPDATE;
    w.wrench   = '{IN_W'(w0), IN_W'(w1), IN_W'(w2), IN_W'(w3), IN_W'(w4), IN_W'(w5)};
    w.failsafe = fs;
    return w;
  endfunction

  function automatic cmd_word_t load_word(input int r, input int c, input int value,
                                          input bit fs);
    cmd_word_t w;
    w          = random_word();
    w.opcode   = OP_LOAD;
    w.row      = MIDX_W'(r);
    w.col      = MIDX_W'(c);
    w.coef     = IN_W'(value);
    w.failsafe = fs;
    return w;
  endfunction

  // ---------------------------------------------------------------- channel drivers

  // offer one word, maybe after an idle burst; valid stays up for a following word
  task automatic send_word(input cmd_word_t w);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= w.opcode;
    in_ch.coef_row   <= w.row;
    in_ch.coef_col   <= w.col;
    in_ch.coef_value <= w.coef;
    in_ch.wrench_0   <= w.wrench[0];
    in_ch.wrench_1   <= w.wrench[1];
    in_ch.wrench_2   <= w.wrench[2];
    in_ch.wrench_3   <= w.wrench[3];
    in_ch.wrench_4   <= w.wrench[4];
    in_ch.wrench_5   <= w.wrench[5];
    in_ch.failsafe   <= w.failsafe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, wait for every predicted result, then let a trailing load finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back register writes; with poke_spare the spare indexes go first so their lack of effect shows
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] alpha_word,
                               input logic [CFG_DATA_W-1:0] inv_word,
                               input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx_seq [4];
    logic [CFG_DATA_W-1:0] dat_seq [4];
    int                    first;
    idx_seq = '{CFG_SPARE_2, CFG_SPARE_3, CFG_FILTER_ALPHA, CFG_INV_THRUST_SCALE};
    dat_seq = '{CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), alpha_word, inv_word};
    first   = poke_spare ? 0 : 2;
    for (int k = first; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_seq[k];
      cfg_ch.data  <= dat_seq[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result receiver

  // ready drops in short random bursts, plus one long hold-off on request
  initial begin
    int hold_left;
    int squeeze_seen;
    hold_left    = 0;
    squeeze_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (squeeze_seen != squeeze_reqs) begin
        squeeze_seen++;
        hold_left = SQUEEZE_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_LOAD;
    in_ch.coef_row   <= '0;
    in_ch.coef_col   <= '0;
    in_ch.coef_value <= '0;
    in_ch.wrench_0   <= '0;
    in_ch.wrench_1   <= '0;
    in_ch.wrench_2   <= '0;
    in_ch.wrench_3   <= '0;
    in_ch.wrench_4   <= '0;
    in_ch.wrench_5   <= '0;
    in_ch.failsafe   <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    rst_n            <= 1'b0;
    recv_gaps        <= 1'b1;
    send_gaps        = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // identity allocation table first: no update may read an unwritten entry
    for (int r = 0; r < NUM_MOTORS; r++)
      for (int c = 0; c < NUM_MOTORS; c++)
        send_word(load_word(r, c, (r == c) ? COEF_ONE : 0, $urandom_range(0, 1)));

    // reset configuration: idle wrench, full wrench, failsafe neutral
    send_word(update_word(0, 0, 0, 0, 0, 0, 1'b0));
    send_word(update_word(WR_MAX, WR_MAX, WR_MAX, WR_MAX, WR_MAX, WR_MAX, 1'b0));
    send_word(update_word(WR_MAX, WR_MAX, WR_MAX, WR_MAX, WR_MAX, WR_MAX, 1'b1));

    // fast filter and 16x gain, so one motor lands in each deadband region
    settle();
    apply_setting(32'h0000_ffff, 32'h0010_0000, 1'b0);
    send_word(update_word(WR_MAX, WR_MIN, 12800, -12800, 16, -16, 1'b0));
    send_word(update_word(WR_MAX, WR_MIN, 12800, -12800, 16, -16, 1'b0));
    send_word(update_word(0, 0, 0, 0, 0, 0, 1'b0));
    // loads outside the table are dropped
    send_word(load_word(6, 0, WR_MAX, 1'b0));
    send_word(load_word(0, 7, WR_MIN, 1'b0));
    send_word(load_word(7, 7, WR_MAX, 1'b1));
    // extreme coefficients, one carrying a stray failsafe bit
    send_word(load_word(0, 0, WR_MAX, 1'b1));
    send_word(load_word(5, 5, WR_MIN, 1'b0));
    send_word(update_word(WR_MIN, WR_MIN, WR_MIN, WR_MIN, WR_MIN, WR_MIN, 1'b0));
    // failsafe must leave the filters where they were
    send_word(update_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1));
    send_word(update_word(0, 0, 0, 0, 0, 0, 1'b0));
    send_word(update_word(16, -16, 32, -32, 256, -256, 1'b0));

    // random phases, each under its own register setting
    for (int p = 1; p <= 6; p++) begin
      settle();
      case (p)
        1: apply_setting(32'(ALPHA_RESET), INV_RESET, 1'b0);
        2: apply_setting(32'h0000_0000, 32'hffff_ffff, 1'b0);  // filters frozen
        3: apply_setting(32'h0000_ffff, 32'h0000_0000, 1'b0);  // zero drive
        4: apply_setting(32'h0000_ffff, 32'hffff_ffff, 1'b0);  // heavy saturation
        5: apply_setting(32'($urandom_range(1, 65534)),
                         32'($urandom_range(32'h0000_4000, 32'h0040_0000)), 1'b0);
        default: apply_setting({16'($urandom), 16'($urandom_range(20000, 65535))},
                               32'h0004_0000, 1'b1);  // junk in the upper alpha bits
      endcase
      // the block has to back up against a stalled result at least once
      if (p == 1) squeeze_reqs <= squeeze_reqs + 1;
      // last stretch runs flat out on both sides
      if (p == 6) begin
        send_gaps = 1'b0;
        recv_gaps <= 1'b0;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p != 6 && k % GAP_CHUNK == 0) begin
          send_gaps = ($urandom_range(0, 3) != 0);
          recv_gaps <= ($urandom_range(0, 3) != 0);
        end
        send_word(random_word());
      end
    end

    settle();
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
